// ----- src/grt_pkg.sv -----
package grt_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned XW     = 9;   // start, write and hit coordinates
  localparam int unsigned VW     = 8;   // occupancy cell value
  localparam int unsigned ENDW   = 13;  // signed ray end coordinates
  localparam int unsigned DIMW   = 10;  // map_width / map_height registers
  localparam int unsigned DISTW  = 19;  // squared distance
  localparam int unsigned KINDW  = 2;

  // Internal widths.
  localparam int unsigned DW     = 13;  // |end - start| along one axis
  localparam int unsigned CW     = 14;  // signed walk coordinate
  localparam int unsigned ERRW   = 16;  // signed Bresenham error term
  localparam int unsigned SQW    = 2 * DIMW;

  localparam int unsigned MAP_DIM_DEFAULT = 512;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd2;

  localparam logic signed [VW-1:0] THRESHOLD_RESET = 8'sd0;
  localparam logic [DIMW-1:0]      DIM_RESET       = 10'd512;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  typedef enum logic [KINDW-1:0] {
    KIND_WRITE = 2'd0,
    KIND_MISS  = 2'd1,
    KIND_HIT   = 2'd2,
    KIND_OUT   = 2'd3
  } grt_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_WRITE,
    ST_READ,
    ST_TEST,
    ST_SQUARE,
    ST_DONE
  } grt_state_t;

  // One classified command as it waits between the front and the walker.
  typedef struct packed {
    logic                  is_cast;
    logic [XW-1:0]         px;        // write cell or ray origin
    logic [XW-1:0]         py;
    logic signed [VW-1:0]  value;
    logic                  x_major;
    logic                  step_x_neg;
    logic                  step_y_neg;
    logic [DW-1:0]         dmaj;
    logic [DW-1:0]         dmin;
  } grt_desc_t;

endpackage

// ----- src/grid_ray_cast_top.sv -----
// Occupancy grid with a line-walking ray caster.
// Input channel: a transaction is taken when in_push is high and in_full is low.
// in_command selects a cell write (in_write_x/y/value) or a ray cast from
// (in_start_x, in_start_y) toward the signed end point (in_end_x, in_end_y).
// Result channel: while out_empty is low the oldest result sits on the out_
// ports; out_pop takes it. Every input transaction gives exactly one result.
// Configuration: cfg_we writes register cfg_index (0 threshold, 1 map width,
// 2 map height); write only while no transaction is in flight.
// Steps: a write goes through the queue pop, the address multiply, the grid
// memory write and the hand-over to the result register. A cast pops the
// queue and visits each cell with an address multiply, a grid memory read and
// a test, squares the distances on a hit, then hands over the result.
// The walk length, bounded by the map size, sets the throughput.
// A two-entry command queue sits in front of the walker and a result register
// behind it, so commands keep being taken while a result waits for out_pop;
// when the receiver stalls, the walker holds its finished result and the
// queue then fills and raises in_full.
// Reset returns the registers to threshold 0 and a 512 by 512 map and empties
// both queues. The grid contents are undefined until written by software.
module grid_ray_cast_top #(
  parameter int unsigned MAP_DIM = grt_pkg::MAP_DIM_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  logic                                  in_command,
  input  logic [grt_pkg::XW-1:0]                in_write_x,
  input  logic [grt_pkg::XW-1:0]                in_write_y,
  input  logic signed [grt_pkg::VW-1:0]         in_write_value,
  input  logic [grt_pkg::XW-1:0]                in_start_x,
  input  logic [grt_pkg::XW-1:0]                in_start_y,
  input  logic signed [grt_pkg::ENDW-1:0]       in_end_x,
  input  logic signed [grt_pkg::ENDW-1:0]       in_end_y,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output logic [grt_pkg::KINDW-1:0]             out_result_kind,
  output logic [grt_pkg::XW-1:0]                out_hit_x,
  output logic [grt_pkg::XW-1:0]                out_hit_y,
  output logic [grt_pkg::DISTW-1:0]             out_distance_squared,
  input  logic                                  cfg_we,
  input  logic [grt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [grt_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // The grid is stored row by row with the configured width as the stride.
  localparam int unsigned DEPTH = MAP_DIM * MAP_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic signed [grt_pkg::VW-1:0] threshold_r;
  logic [grt_pkg::DIMW-1:0]      map_width_r, map_height_r;
  logic [grt_pkg::DIMW-1:0]      map_w, map_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= grt_pkg::THRESHOLD_RESET;
      map_width_r  <= grt_pkg::DIM_RESET;
      map_height_r <= grt_pkg::DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        grt_pkg::REG_THRESHOLD:  threshold_r  <= $signed(cfg_wdata[grt_pkg::VW-1:0]);
        grt_pkg::REG_MAP_WIDTH:  map_width_r  <= cfg_wdata;
        grt_pkg::REG_MAP_HEIGHT: map_height_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Dimensions larger than the physical grid saturate at its size.
  assign map_w = (map_width_r > MAP_DIM)  ? grt_pkg::DIMW'(MAP_DIM) : map_width_r;
  assign map_h = (map_height_r > MAP_DIM) ? grt_pkg::DIMW'(MAP_DIM) : map_height_r;

  logic               q_empty, q_pop;
  grt_pkg::grt_desc_t q_desc;

  grt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .command     (in_command),
    .write_x     (in_write_x),
    .write_y     (in_write_y),
    .write_value (in_write_value),
    .start_x     (in_start_x),
    .start_y     (in_start_y),
    .end_x       (in_end_x),
    .end_y       (in_end_y),
    .q_empty     (q_empty),
    .q_desc      (q_desc),
    .q_pop       (q_pop)
  );

  logic [AW-1:0]          ram_addr;
  logic                   ram_we, ram_re;
  logic [grt_pkg::VW-1:0] ram_wdata, ram_rdata;

  grt_ram #(
    .WIDTH (grt_pkg::VW),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (ram_wdata),
    .re    (ram_re),
    .rdata (ram_rdata)
  );

  grt_back #(
    .AW (AW)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .threshold            (threshold_r),
    .map_w                (map_w),
    .map_h                (map_h),
    .q_empty              (q_empty),
    .q_desc               (q_desc),
    .q_pop                (q_pop),
    .ram_addr             (ram_addr),
    .ram_we               (ram_we),
    .ram_wdata            (ram_wdata),
    .ram_re               (ram_re),
    .ram_rdata            (ram_rdata),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_result_kind      (out_result_kind),
    .out_hit_x            (out_hit_x),
    .out_hit_y            (out_hit_y),
    .out_distance_squared (out_distance_squared)
  );

endmodule

// ----- src/grt_ram.sv -----
module grt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/grt_front.sv -----
module grt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic                                command,
  input  logic [grt_pkg::XW-1:0]              write_x,
  input  logic [grt_pkg::XW-1:0]              write_y,
  input  logic signed [grt_pkg::VW-1:0]       write_value,
  input  logic [grt_pkg::XW-1:0]              start_x,
  input  logic [grt_pkg::XW-1:0]              start_y,
  input  logic signed [grt_pkg::ENDW-1:0]     end_x,
  input  logic signed [grt_pkg::ENDW-1:0]     end_y,
  output logic                                q_empty,
  output grt_pkg::grt_desc_t                  q_desc,
  input  logic                                q_pop
);

  localparam int unsigned SDW = grt_pkg::DW + 1;

  grt_pkg::grt_desc_t desc;
  logic signed [SDW-1:0] dx, dy;
  logic [grt_pkg::DW-1:0] adx, ady;

  // Classify the command and set up the line parameters.
  always_comb begin
    dx  = $signed({end_x[grt_pkg::ENDW-1], end_x})
        - $signed({{(SDW-grt_pkg::XW){1'b0}}, start_x});
    dy  = $signed({end_y[grt_pkg::ENDW-1], end_y})
        - $signed({{(SDW-grt_pkg::XW){1'b0}}, start_y});
    adx = dx[SDW-1] ? grt_pkg::DW'(-dx) : grt_pkg::DW'(dx);
    ady = dy[SDW-1] ? grt_pkg::DW'(-dy) : grt_pkg::DW'(dy);

    desc.is_cast    = (command == grt_pkg::CMD_CAST);
    desc.px         = desc.is_cast ? start_x : write_x;
    desc.py         = desc.is_cast ? start_y : write_y;
    desc.value      = write_value;
    desc.x_major    = (ady < adx);
    desc.step_x_neg = dx[SDW-1];
    desc.step_y_neg = dy[SDW-1];
    desc.dmaj       = desc.x_major ? adx : ady;
    desc.dmin       = desc.x_major ? ady : adx;
  end

  // Two-entry queue toward the walker.
  grt_pkg::grt_desc_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign q_empty = (count_r == 2'd0);
  assign q_desc  = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= desc;
    end
  end

endmodule

// ----- src/grt_back.sv -----
module grt_back #(
  parameter int unsigned AW = 18
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic signed [grt_pkg::VW-1:0]   threshold,
  input  logic [grt_pkg::DIMW-1:0]        map_w,
  input  logic [grt_pkg::DIMW-1:0]        map_h,
  input  logic                            q_empty,
  input  grt_pkg::grt_desc_t              q_desc,
  output logic                            q_pop,
  output logic [AW-1:0]                   ram_addr,
  output logic                            ram_we,
  output logic [grt_pkg::VW-1:0]          ram_wdata,
  output logic                            ram_re,
  input  logic [grt_pkg::VW-1:0]          ram_rdata,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [grt_pkg::KINDW-1:0]       out_result_kind,
  output logic [grt_pkg::XW-1:0]          out_hit_x,
  output logic [grt_pkg::XW-1:0]          out_hit_y,
  output logic [grt_pkg::DISTW-1:0]       out_distance_squared
);

  localparam int unsigned CW   = grt_pkg::CW;
  localparam int unsigned DIMW = grt_pkg::DIMW;
  localparam int unsigned PW   = 2 * DIMW + 1;

  grt_pkg::grt_state_t state_r, state_nxt;

  logic                          is_cast_r;
  logic signed [grt_pkg::VW-1:0] value_r;
  logic [grt_pkg::XW-1:0]        sx_r, sy_r;
  logic signed [CW-1:0]          cx_r, cy_r;
  logic signed [grt_pkg::ERRW-1:0] err_r;
  logic [grt_pkg::DW-1:0]        k_r, dmaj_r, dmin_r;
  logic                          x_major_r, sxn_r, syn_r;
  logic [AW-1:0]                 addr_r;
  grt_pkg::grt_kind_t            kind_r;
  logic [grt_pkg::SQW-1:0]       sqx_r, sqy_r;

  logic                          out_valid_r;
  grt_pkg::grt_kind_t            out_kind_r;
  logic [grt_pkg::XW-1:0]        out_hx_r, out_hy_r;
  logic [grt_pkg::DISTW-1:0]     out_dist_r;

  logic                          in_map, hit, last_cell, out_load;
  logic [PW-1:0]                 addr_calc;
  logic                          err_pos, step_x, step_y;
  logic signed [CW-1:0]          cx_nxt, cy_nxt;
  logic signed [grt_pkg::ERRW-1:0] dmin2, dmaj2, err_nxt;
  logic signed [CW-1:0]          ddx, ddy;
  logic [DIMW-1:0]               adx, ady;

  // Datapath helpers.
  always_comb begin
    in_map = !cx_r[CW-1] && !cy_r[CW-1]
          && (cx_r[CW-2:0] < (CW-1)'(map_w))
          && (cy_r[CW-2:0] < (CW-1)'(map_h));
    addr_calc = PW'(cy_r[DIMW-1:0] * map_w) + PW'(cx_r[DIMW-1:0]);
    hit       = $signed(ram_rdata) > threshold;
    last_cell = (k_r == dmaj_r);

    dmin2   = $signed({2'b00, dmin_r, 1'b0});
    dmaj2   = $signed({2'b00, dmaj_r, 1'b0});
    err_pos = !err_r[grt_pkg::ERRW-1] && (err_r != '0);
    err_nxt = err_r + dmin2 - (err_pos ? dmaj2 : '0);
    step_x  = x_major_r || err_pos;
    step_y  = !x_major_r || err_pos;
    cx_nxt  = step_x ? (sxn_r ? cx_r - CW'(1) : cx_r + CW'(1)) : cx_r;
    cy_nxt  = step_y ? (syn_r ? cy_r - CW'(1) : cy_r + CW'(1)) : cy_r;

    ddx = cx_r - $signed(CW'(sx_r));
    ddy = cy_r - $signed(CW'(sy_r));
    adx = ddx[CW-1] ? DIMW'(-ddx) : DIMW'(ddx);
    ady = ddy[CW-1] ? DIMW'(-ddy) : DIMW'(ddy);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      grt_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = grt_pkg::ST_ADDR;
        end
      end
      grt_pkg::ST_ADDR: begin
        if (!in_map) begin
          state_nxt = grt_pkg::ST_DONE;
        end else if (is_cast_r) begin
          state_nxt = grt_pkg::ST_READ;
        end else begin
          state_nxt = grt_pkg::ST_WRITE;
        end
      end
      grt_pkg::ST_WRITE: state_nxt = grt_pkg::ST_DONE;
      grt_pkg::ST_READ:  state_nxt = grt_pkg::ST_TEST;
      grt_pkg::ST_TEST: begin
        if (hit) begin
          state_nxt = grt_pkg::ST_SQUARE;
        end else if (last_cell) begin
          state_nxt = grt_pkg::ST_DONE;
        end else begin
          state_nxt = grt_pkg::ST_ADDR;
        end
      end
      grt_pkg::ST_SQUARE: state_nxt = grt_pkg::ST_DONE;
      grt_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = grt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = grt_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop    = (state_r == grt_pkg::ST_IDLE) && !q_empty;
    ram_we   = (state_r == grt_pkg::ST_WRITE);
    ram_re   = (state_r == grt_pkg::ST_READ);
    out_load = (state_r == grt_pkg::ST_DONE) && (!out_valid_r || out_pop);
  end

  assign ram_addr  = addr_r;
  assign ram_wdata = value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grt_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      grt_pkg::ST_IDLE: begin
        is_cast_r <= q_desc.is_cast;
        value_r   <= q_desc.value;
        sx_r      <= q_desc.px;
        sy_r      <= q_desc.py;
        cx_r      <= CW'(q_desc.px);
        cy_r      <= CW'(q_desc.py);
        x_major_r <= q_desc.x_major;
        sxn_r     <= q_desc.step_x_neg;
        syn_r     <= q_desc.step_y_neg;
        dmaj_r    <= q_desc.dmaj;
        dmin_r    <= q_desc.dmin;
        err_r     <= $signed({2'b00, q_desc.dmin, 1'b0})
                   - $signed({3'b000, q_desc.dmaj});
        k_r       <= '0;
      end
      grt_pkg::ST_ADDR: begin
        addr_r <= AW'(addr_calc);
        if (!is_cast_r) begin
          kind_r <= grt_pkg::KIND_WRITE;
        end else if (!in_map) begin
          kind_r <= grt_pkg::KIND_OUT;
        end
      end
      grt_pkg::ST_TEST: begin
        if (hit) begin
          kind_r <= grt_pkg::KIND_HIT;
        end else if (last_cell) begin
          kind_r <= grt_pkg::KIND_MISS;
        end else begin
          cx_r  <= cx_nxt;
          cy_r  <= cy_nxt;
          err_r <= err_nxt;
          k_r   <= k_r + grt_pkg::DW'(1);
        end
      end
      grt_pkg::ST_SQUARE: begin
        sqx_r <= adx * adx;
        sqy_r <= ady * ady;
      end
      default: begin
      end
    endcase
  end

  // Result register: lets the walker take the next command while a result waits.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= kind_r;
      if (kind_r == grt_pkg::KIND_HIT) begin
        out_hx_r   <= cx_r[grt_pkg::XW-1:0];
        out_hy_r   <= cy_r[grt_pkg::XW-1:0];
        out_dist_r <= grt_pkg::DISTW'({1'b0, sqx_r} + {1'b0, sqy_r});
      end else begin
        out_hx_r   <= '0;
        out_hy_r   <= '0;
        out_dist_r <= '0;
      end
    end
  end

  assign out_empty            = !out_valid_r;
  assign out_result_kind      = out_kind_r;
  assign out_hit_x            = out_hx_r;
  assign out_hit_y            = out_hy_r;
  assign out_distance_squared = out_dist_r;

endmodule

// ----- src/grt_checker.sv -----
module grt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_full,
  input logic                            out_empty,
  input logic                            out_pop,
  input logic [grt_pkg::KINDW-1:0]       out_result_kind,
  input logic [grt_pkg::XW-1:0]          out_hit_x,
  input logic [grt_pkg::XW-1:0]          out_hit_y,
  input logic [grt_pkg::DISTW-1:0]       out_distance_squared
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_result_kind)
      && $stable(out_hit_x) && $stable(out_hit_y) && $stable(out_distance_squared))
    else $error("waiting result changed");

  // Only a hit carries a cell and a distance.
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind != grt_pkg::KIND_HIT |->
      out_hit_x == '0 && out_hit_y == '0 && out_distance_squared == '0)
    else $error("non-hit result with nonzero fields");

  // A miss never carries a distance.
  a_hit_distance: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_result_kind == grt_pkg::KIND_MISS |->
      out_distance_squared == '0)
    else $error("miss with distance");

endmodule

bind grid_ray_cast_top grt_checker u_grt_checker (.*);

// ----- tb/grid_ray_cast_top_test.sv -----
import grt_pkg::*;

// One command as offered on the input channel. Fields that the command does
// not use still carry random values, since the block must ignore them.
typedef struct {
  logic                   command;
  logic [XW-1:0]          write_x;
  logic [XW-1:0]          write_y;
  logic signed [VW-1:0]   write_value;
  logic [XW-1:0]          start_x;
  logic [XW-1:0]          start_y;
  logic signed [ENDW-1:0] end_x;
  logic signed [ENDW-1:0] end_y;
} grid_cmd_t;

typedef struct {
  grt_kind_t        kind;
  logic [XW-1:0]    hit_x;
  logic [XW-1:0]    hit_y;
  logic [DISTW-1:0] dist_sq;
} cast_result_t;

// Mirror of the occupancy grid and the registers, plus the results still owed.
class cast_scoreboard;
  localparam int GRID_CELLS = MAP_DIM_DEFAULT * MAP_DIM_DEFAULT;

  logic signed [VW-1:0] cells [GRID_CELLS];
  bit                   written [GRID_CELLS];
  int                   threshold;
  int                   width_reg;
  int                   height_reg;
  cast_result_t         awaited [$];
  int                   mismatches;
  int                   checked;
  int                   n_write;
  int                   n_miss;
  int                   n_hit;
  int                   n_out;

  function new();
    threshold  = 0;
    width_reg  = MAP_DIM_DEFAULT;
    height_reg = MAP_DIM_DEFAULT;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_THRESHOLD:  threshold  = $signed(data[VW-1:0]);
      REG_MAP_WIDTH:  width_reg  = data;
      REG_MAP_HEIGHT: height_reg = data;
      default: ;
    endcase
  endfunction

  // Dimensions above the grid size saturate.
  function int eff_width();
    return (width_reg > int'(MAP_DIM_DEFAULT)) ? int'(MAP_DIM_DEFAULT) : width_reg;
  endfunction

  function int eff_height();
    return (height_reg > int'(MAP_DIM_DEFAULT)) ? int'(MAP_DIM_DEFAULT) : height_reg;
  endfunction

  // Applies one accepted command to the mirror and queues the result it owes.
  function void note_input(grid_cmd_t c);
    cast_result_t r;
    int w, h, x, y, ex, ey, adx, ady, dmaj, dmin, err, stx, sty, cx, cy, k, addr;
    bit x_major;
    w = eff_width();
    h = eff_height();
    r.kind    = KIND_WRITE;
    r.hit_x   = '0;
    r.hit_y   = '0;
    r.dist_sq = '0;
    if (c.command == CMD_WRITE) begin
      x = c.write_x;
      y = c.write_y;
      // A write outside the map in use leaves the grid alone.
      if (x < w && y < h) begin
        addr          = y * w + x;
        cells[addr]   = c.write_value;
        written[addr] = 1'b1;
      end
      n_write++;
    end else begin
      x       = c.start_x;
      y       = c.start_y;
      ex      = c.end_x;
      ey      = c.end_y;
      adx     = (ex > x) ? ex - x : x - ex;
      ady     = (ey > y) ? ey - y : y - ey;
      stx     = (ex < x) ? -1 : 1;
      sty     = (ey < y) ? -1 : 1;
      x_major = (ady < adx);
      dmaj    = x_major ? adx : ady;
      dmin    = x_major ? ady : adx;
      err     = 2 * dmin - dmaj;
      cx      = x;
      cy      = y;
      r.kind  = KIND_MISS;
      for (k = 0; k <= dmaj; k++) begin
        if (cx < 0 || cy < 0 || cx >= w || cy >= h) begin
          r.kind = KIND_OUT;
          break;
        end
        addr = cy * w + cx;
        if (cells[addr] > threshold) begin
          r.kind    = KIND_HIT;
          r.hit_x   = XW'(cx);
          r.hit_y   = XW'(cy);
          r.dist_sq = DISTW'((cx - x) * (cx - x) + (cy - y) * (cy - y));
          break;
        end
        if (err > 0) begin
          if (x_major) cy += sty;
          else cx += stx;
          err -= 2 * dmaj;
        end
        err += 2 * dmin;
        if (x_major) cx += stx;
        else cy += sty;
      end
      case (r.kind)
        KIND_MISS: n_miss++;
        KIND_HIT:  n_hit++;
        default:   n_out++;
      endcase
    end
    awaited.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function void check_result(cast_result_t got);
    cast_result_t want;
    if (awaited.size() == 0) begin
      $display("%0t: result kind %0d arrived with nothing outstanding", $time, got.kind);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    checked++;
    compare_field("result_kind", want.kind, got.kind);
    compare_field("hit_x", want.hit_x, got.hit_x);
    compare_field("hit_y", want.hit_y, got.hit_y);
    compare_field("distance_squared", want.dist_sq, got.dist_sq);
  endfunction
endclass

module grid_ray_cast_top_test;

  localparam int GAP_MAX     = 18;
  localparam int HOLD_CYCLES = 400;
  // The slowest legal gap between two transactions is a full-width walk of
  // 512 cells or the long receiver hold-off; the limit sits well above both.
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;
  localparam int N_PHASES    = 9;

  logic                   clk;
  logic                   rst_n;
  logic                   in_push;
  logic                   in_full;
  logic                   in_command;
  logic [XW-1:0]          in_write_x;
  logic [XW-1:0]          in_write_y;
  logic signed [VW-1:0]   in_write_value;
  logic [XW-1:0]          in_start_x;
  logic [XW-1:0]          in_start_y;
  logic signed [ENDW-1:0] in_end_x;
  logic signed [ENDW-1:0] in_end_y;
  logic                   out_empty;
  logic                   out_pop;
  logic [KINDW-1:0]       out_result_kind;
  logic [XW-1:0]          out_hit_x;
  logic [XW-1:0]          out_hit_y;
  logic [DISTW-1:0]       out_distance_squared;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  grid_ray_cast_top u_dut (.*);

  cast_scoreboard sb;

  // Idle pattern state for each side: a stretch of items either all taken
  // back to back, or each with a random wait.
  int send_left  = 0;
  bit send_eager = 1'b0;
  int recv_left  = 0;
  bit recv_eager = 1'b0;
  int stall_cycles = 0;

  // Each phase loads one register setting, tops up the grid and then runs
  // random traffic. The settings visit the threshold extremes, a single-row
  // and a single-column map, zero dimensions and an oversized width.
  int phase_thr [N_PHASES] = '{50, -1, 100, 30, 20, 40, 60, 0, 75};
  int phase_w   [N_PHASES] = '{16, 512, 1, 0, 1023, 24, 37, 9, 100};
  int phase_h   [N_PHASES] = '{16, 1, 512, 20, 1, 0, 13, 40, 5};
  int phase_n   [N_PHASES] = '{60, 40, 30, 25, 40, 15, 40, 35, 35};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap(inout int left, inout bit eager);
    if (left == 0) begin
      left  = $urandom_range(4, 40);
      eager = ($urandom_range(0, 2) == 0);
    end
    left--;
    return eager ? 0 : int'($urandom_range(0, GAP_MAX));
  endfunction

  // Mostly free cells, with a minority above most of the thresholds in use.
  function automatic int pick_value();
    if ($urandom_range(0, 99) < 85) return int'($urandom_range(0, 25)) - 1;
    return int'($urandom_range(26, 100));
  endfunction

  function automatic grid_cmd_t junk_cmd();
    grid_cmd_t c;
    c.command     = 1'($urandom_range(0, 1));
    c.write_x     = XW'($urandom_range(0, 511));
    c.write_y     = XW'($urandom_range(0, 511));
    c.write_value = VW'($urandom_range(0, 255));
    c.start_x     = XW'($urandom_range(0, 511));
    c.start_y     = XW'($urandom_range(0, 511));
    c.end_x       = ENDW'($urandom_range(0, 8191));
    c.end_y       = ENDW'($urandom_range(0, 8191));
    return c;
  endfunction

  function automatic grid_cmd_t make_write(int x, int y, int v);
    grid_cmd_t c;
    c             = junk_cmd();
    c.command     = CMD_WRITE;
    c.write_x     = XW'(x);
    c.write_y     = XW'(y);
    c.write_value = VW'(v);
    return c;
  endfunction

  function automatic grid_cmd_t make_cast(int sx, int sy, int ex, int ey);
    grid_cmd_t c;
    c         = junk_cmd();
    c.command = CMD_CAST;
    c.start_x = XW'(sx);
    c.start_y = XW'(sy);
    c.end_x   = ENDW'(ex);
    c.end_y   = ENDW'(ey);
    return c;
  endfunction

  // Most casts start on the map and end just around it, so that walks cross
  // free cells and stop on obstacles or at the border. The rest use the whole
  // coordinate range, with origins that may lie off the map.
  function automatic grid_cmd_t random_cmd();
    grid_cmd_t c;
    int w, h, pick;
    bit on_map;
    w      = sb.eff_width();
    h      = sb.eff_height();
    on_map = (w > 0 && h > 0);
    c      = junk_cmd();
    pick   = $urandom_range(0, 99);
    if (pick < 30) begin
      c.command     = CMD_WRITE;
      c.write_value = VW'(pick_value());
      if (on_map && pick < 22) begin
        c.write_x = XW'($urandom_range(0, w - 1));
        c.write_y = XW'($urandom_range(0, h - 1));
      end
    end else begin
      c.command = CMD_CAST;
      if (on_map && pick < 90) begin
        c.start_x = XW'($urandom_range(0, w - 1));
        c.start_y = XW'($urandom_range(0, h - 1));
        if (pick < 78) begin
          c.end_x = ENDW'(int'($urandom_range(0, w + 7)) - 4);
          c.end_y = ENDW'(int'($urandom_range(0, h + 7)) - 4);
        end
      end
    end
    return c;
  endfunction

  // Offers one command and returns at the edge where it is taken. in_push is
  // left high so that a following command without a gap goes out at once.
  task automatic send_item(grid_cmd_t c);
    int gap;
    gap = draw_gap(send_left, send_eager);
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_command     <= c.command;
    in_write_x     <= c.write_x;
    in_write_y     <= c.write_y;
    in_write_value <= c.write_value;
    in_start_x     <= c.start_x;
    in_start_y     <= c.start_y;
    in_end_x       <= c.end_x;
    in_end_y       <= c.end_y;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(c);
  endtask

  // The sender stops and waits until every owed result has been taken.
  task automatic wait_all_results();
    in_push <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Registers only change with nothing in flight. The threshold write also
  // carries random upper data bits that the register must drop.
  task automatic load_config(int thr, int w, int h);
    logic [CFG_IDX_W-1:0]  regs [3] = '{REG_THRESHOLD, REG_MAP_WIDTH, REG_MAP_HEIGHT};
    logic [CFG_DATA_W-1:0] vals [3];
    wait_all_results();
    vals[0] = {2'($urandom_range(0, 3)), VW'(thr)};
    vals[1] = CFG_DATA_W'(w);
    vals[2] = CFG_DATA_W'(h);
    for (int i = 0; i < 3; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // The grid is undefined until written, and a cast may read any cell of the
  // map in use. Every store address the current dimensions reach is written
  // once before any random cast runs.
  task automatic fill_map();
    int w, h;
    w = sb.eff_width();
    h = sb.eff_height();
    for (int a = 0; a < w * h; a++)
      if (!sb.written[a]) send_item(make_write(a % w, a / w, pick_value()));
  endtask

  initial begin : stimulus
    sb = new();
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_command     <= CMD_WRITE;
    in_write_x     <= '0;
    in_write_y     <= '0;
    in_write_value <= '0;
    in_start_x     <= '0;
    in_start_y     <= '0;
    in_end_x       <= '0;
    in_end_y       <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_THRESHOLD;
    cfg_wdata      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: a 512 by 512 map with nothing written. Only the corner
    // cells are written, so the casts here hit at their own origin with a
    // distance of zero and never read further.
    send_item(make_write(0, 0, 100));
    send_item(make_write(511, 511, 100));
    send_item(make_cast(0, 0, 4095, -4096));
    send_item(make_cast(511, 511, -4096, 4095));

    for (int p = 0; p < N_PHASES; p++) begin
      load_config(phase_thr[p], phase_w[p], phase_h[p]);
      fill_map();
      if (p == 0) begin
        // Hand-picked walks on the 16 by 16 map: both directions of an x-major
        // and a y-major line, a diagonal where the tie goes to y, a single
        // cell ray, a sure miss, a walk that runs off the right edge, an
        // origin off the map and two writes that fall outside it.
        send_item(make_write(12, 3, 100));
        send_item(make_cast(2, 3, 14, 3));
        send_item(make_cast(14, 3, 2, 3));
        send_item(make_cast(5, 1, 7, 14));
        send_item(make_cast(7, 14, 5, 1));
        send_item(make_cast(0, 15, 15, 0));
        send_item(make_cast(4, 4, 4, 4));
        send_item(make_write(3, 5, 0));
        send_item(make_write(4, 5, -1));
        send_item(make_cast(3, 5, 4, 5));
        send_item(make_write(15, 9, -1));
        send_item(make_cast(15, 9, 4095, 9));
        send_item(make_cast(20, 3, 0, 0));
        send_item(make_write(16, 0, 100));
        send_item(make_write(0, 16, 100));
      end
      repeat (phase_n[p]) send_item(random_cmd());
    end

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Checked %0d results over %0d register settings: %0d writes, %0d hits,",
             sb.checked, N_PHASES + 1, sb.n_write, sb.n_hit);
    $display("%0d misses and %0d casts stopped off the map; %0d mismatches.",
             sb.n_miss, sb.n_out, sb.mismatches);
    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result side. Twice during the run the receiver holds off for a long
  // stretch while the sender keeps offering, so the command queue and the
  // result register fill up and in_full must hold the input back.
  initial begin : result_side
    cast_result_t got;
    int gap;
    out_pop <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = draw_gap(recv_left, recv_eager);
      if (sb.checked == 150 || sb.checked == 700) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty) @(posedge clk);
      got.kind    = grt_kind_t'(out_result_kind);
      got.hit_x   = out_hit_x;
      got.hit_y   = out_hit_y;
      got.dist_sq = out_distance_squared;
      sb.check_result(got);
    end
  end

  // Watchdog: any stretch without a transaction on either channel longer
  // than the slowest correct walk means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
src/grt_pkg.sv
src/grt_ram.sv
src/grt_front.sv
src/grt_back.sv
src/grid_ray_cast_top.sv
src/grt_checker.sv
tb/grid_ray_cast_top_test.sv
